FILE: sv/hzb_pkg.sv
// Shared types, widths and constants of the habitable-zone boundary pipeline.
package hzb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;

  localparam int TEMP_W  = 17;
  localparam int LUM_W   = 43;
  localparam int DIST_W  = 31;
  localparam int RATIO_W = FRAC_BITS + 1;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int T_W     = TEMP_W + 1;
  localparam int ACC_W   = 52;
  localparam int SEFF_W  = ACC_W - 1;
  localparam int PROD_W  = 64;
  localparam int W8_W    = 59;
  localparam int SPLIT_W = 30;
  localparam int RCP_W   = 60;
  localparam int RCP_SH  = 66;
  localparam int LL_W    = 22;
  localparam int LH_W    = LUM_W - LL_W;
  localparam int SCALE_W = 30;
  localparam int PL_W    = LL_W + SCALE_W;
  localparam int PH_W    = LH_W + SCALE_W;
  localparam int NUM_W   = LUM_W + SCALE_W;
  localparam int QUOT_W  = 2 * DIST_W;

  localparam logic [TEMP_W-1:0]  TEMP_REF   = TEMP_W'(5780);
  localparam logic [SCALE_W-1:0] SEFF_SCALE = SCALE_W'(1000000000);
  localparam logic [TEMP_W-1:0]  LOW_RESET  = TEMP_W'(1000);
  localparam logic [TEMP_W-1:0]  HIGH_RESET = TEMP_W'(10000);
  localparam logic [PROD_W-1:0]  FLOOR_OFFSET = PROD_W'(1000) << (ACC_W - 1);
  localparam logic [ACC_W-1:0]   QUOT_OFFSET  = ACC_W'(1) << (ACC_W - 1);
  localparam logic [RCP_W-1:0]   RECIP_125    = 60'd590295810358705652;
  localparam logic [DIST_W-1:0]  DIST_SAT   = {DIST_W{1'b1}};
  localparam logic [RATIO_W-1:0] RATIO_CAP  =
      (FRAC_BITS >= RATIO_W) ? {RATIO_W{1'b1}} : RATIO_W'(1) << FRAC_BITS;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t SEFF_INNER = ACC_W'(1100000000);
  localparam acc_t SEFF_OUTER = ACC_W'(530000000);

  // columns s, a, b, c, d in units of 1e-9
  localparam acc_t FLUX_COEF [LANES][5] = '{
    '{ 52'sd1776000000, 52'sd213600000, 52'sd25330000, -52'sd13320000, -52'sd3097000 },
    '{ 52'sd1107000000, 52'sd133200000, 52'sd15800000, -52'sd8308000,  -52'sd1931000 },
    '{ 52'sd356000000,  52'sd61710000,  52'sd1698000,  -52'sd3198000,  -52'sd557500  },
    '{ 52'sd320000000,  52'sd55470000,  52'sd1526000,  -52'sd2874000,  -52'sd501100  }
  };

  typedef enum logic {
    REG_TEFF_LOW  = 1'b0,
    REG_TEFF_HIGH = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [T_W-1:0] t;
    logic [NUM_W-1:0]      num;
    logic                  fb;
  } hzb_carry_t;

  typedef struct packed {
    logic fb;
    logic bad;
  } hzb_flags_t;

endpackage

FILE: sv/hzb_horner.sv
// One Horner step for all four flux polynomials: multiply, floor-divide by 1000, add.
module hzb_horner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hzb_pkg::hzb_carry_t carry_i,
  input  hzb_pkg::acc_t       acc_i  [hzb_pkg::LANES],
  input  hzb_pkg::acc_t       coef_i [hzb_pkg::LANES],
  output logic                valid_o,
  output hzb_pkg::hzb_carry_t carry_o,
  output hzb_pkg::acc_t       acc_o  [hzb_pkg::LANES]
);

  localparam int STG = 5;
  localparam int PW  = hzb_pkg::ACC_W + hzb_pkg::T_W;
  localparam int PPW = 2 * hzb_pkg::SPLIT_W;
  localparam int FW  = hzb_pkg::RCP_SH + hzb_pkg::ACC_W;

  logic [STG-1:0]                     valid_q;
  hzb_pkg::hzb_carry_t                carry_q [STG];
  logic signed [PW-1:0]               prod    [hzb_pkg::LANES];
  logic signed [hzb_pkg::PROD_W-1:0]  p_q     [hzb_pkg::LANES];
  logic [hzb_pkg::PROD_W-1:0]         zoff    [hzb_pkg::LANES];
  logic [hzb_pkg::W8_W-1:0]           w_q     [hzb_pkg::LANES];
  logic [PPW-1:0]                     hh_q    [hzb_pkg::LANES];
  logic [PPW-1:0]                     hl_q    [hzb_pkg::LANES];
  logic [PPW-1:0]                     lh_q    [hzb_pkg::LANES];
  logic [PPW-1:0]                     ll_q    [hzb_pkg::LANES];
  logic [FW-1:0]                      full    [hzb_pkg::LANES];
  logic [hzb_pkg::ACC_W-1:0]          qz_q    [hzb_pkg::LANES];
  hzb_pkg::acc_t                      acc_q   [hzb_pkg::LANES];

  always_comb begin
    for (int l = 0; l < hzb_pkg::LANES; l++) begin
      prod[l] = acc_i[l] * $signed(carry_i.t);
      zoff[l] = $unsigned(p_q[l]) + hzb_pkg::FLOOR_OFFSET;
      full[l] = (FW'(hh_q[l]) << (2 * hzb_pkg::SPLIT_W)) +
                ((FW'(hl_q[l]) + FW'(lh_q[l])) << hzb_pkg::SPLIT_W) + FW'(ll_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[STG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q[0] <= carry_i;
    for (int s = 1; s < STG; s++) begin
      carry_q[s] <= carry_q[s-1];
    end
    for (int l = 0; l < hzb_pkg::LANES; l++) begin
      p_q[l]  <= prod[l][hzb_pkg::PROD_W-1:0];
      w_q[l]  <= zoff[l][hzb_pkg::W8_W+2:3];
      hh_q[l] <= PPW'(w_q[l][hzb_pkg::W8_W-1:hzb_pkg::SPLIT_W]) *
                 PPW'(hzb_pkg::RECIP_125[hzb_pkg::RCP_W-1:hzb_pkg::SPLIT_W]);
      hl_q[l] <= PPW'(w_q[l][hzb_pkg::W8_W-1:hzb_pkg::SPLIT_W]) *
                 PPW'(hzb_pkg::RECIP_125[hzb_pkg::SPLIT_W-1:0]);
      lh_q[l] <= PPW'(w_q[l][hzb_pkg::SPLIT_W-1:0]) *
                 PPW'(hzb_pkg::RECIP_125[hzb_pkg::RCP_W-1:hzb_pkg::SPLIT_W]);
      ll_q[l] <= PPW'(w_q[l][hzb_pkg::SPLIT_W-1:0]) *
                 PPW'(hzb_pkg::RECIP_125[hzb_pkg::SPLIT_W-1:0]);
      qz_q[l] <= full[l][FW-1:hzb_pkg::RCP_SH];
      acc_q[l] <= $signed(qz_q[l] - hzb_pkg::QUOT_OFFSET) + coef_i[l];
    end
  end

  assign valid_o = valid_q[STG-1];
  assign carry_o = carry_q[STG-1];
  assign acc_o   = acc_q;

endmodule

FILE: sv/hzb_div.sv
// Restoring divider, one quotient bit per stage, for the four scaled luminosity quotients.
module hzb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       fb_i,
  input  logic [hzb_pkg::NUM_W-1:0]  num_i,
  input  hzb_pkg::acc_t              seff_i [hzb_pkg::LANES],
  output logic                       valid_o,
  output logic                       fb_o,
  output logic [hzb_pkg::QUOT_W-1:0] q_o    [hzb_pkg::LANES],
  output logic                       bad_o  [hzb_pkg::LANES]
);

  localparam int LO_W = hzb_pkg::QUOT_W - hzb_pkg::FRAC_BITS;
  localparam int HI_W = hzb_pkg::NUM_W - LO_W;
  localparam int NS   = hzb_pkg::QUOT_W + 1;
  localparam int SW   = hzb_pkg::SEFF_W;

  logic [NS-1:0]              valid_q;
  logic                       fb_q  [NS];
  logic [hzb_pkg::QUOT_W-1:0] nlo_q [NS];
  logic [SW-1:0]              rem_q [NS][hzb_pkg::LANES];
  logic [SW-1:0]              d_q   [NS][hzb_pkg::LANES];
  logic [hzb_pkg::QUOT_W-1:0] q_q   [NS][hzb_pkg::LANES];
  logic                       bad_q [NS][hzb_pkg::LANES];
  logic [HI_W-1:0]            hi;

  assign hi = num_i[hzb_pkg::NUM_W-1:LO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [SW:0] r2;
    logic        ge;
    fb_q[0]  <= fb_i;
    nlo_q[0] <= {num_i[LO_W-1:0], {hzb_pkg::FRAC_BITS{1'b0}}};
    for (int l = 0; l < hzb_pkg::LANES; l++) begin
      rem_q[0][l] <= SW'(hi);
      d_q[0][l]   <= seff_i[l][SW-1:0];
      q_q[0][l]   <= '0;
      bad_q[0][l] <= (seff_i[l] <= 0) || (SW'(hi) >= seff_i[l][SW-1:0]);
    end
    for (int k = 1; k < NS; k++) begin
      fb_q[k]  <= fb_q[k-1];
      nlo_q[k] <= nlo_q[k-1];
      for (int l = 0; l < hzb_pkg::LANES; l++) begin
        r2 = {rem_q[k-1][l], nlo_q[k-1][hzb_pkg::QUOT_W-k]};
        ge = r2 >= {1'b0, d_q[k-1][l]};
        rem_q[k][l] <= ge ? SW'(r2 - {1'b0, d_q[k-1][l]}) : r2[SW-1:0];
        d_q[k][l]   <= d_q[k-1][l];
        q_q[k][l]   <= {q_q[k-1][l][hzb_pkg::QUOT_W-2:0], ge};
        bad_q[k][l] <= bad_q[k-1][l];
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign fb_o    = fb_q[NS-1];
  assign q_o     = q_q[NS-1];
  assign bad_o   = bad_q[NS-1];

endmodule

FILE: sv/hzb_isqrt.sv
// Digit-by-digit integer square root, one root bit per stage, four lanes.
module hzb_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       fb_i,
  input  logic [hzb_pkg::QUOT_W-1:0] q_i    [hzb_pkg::LANES],
  input  logic                       bad_i  [hzb_pkg::LANES],
  output logic                       valid_o,
  output hzb_pkg::hzb_flags_t        flags_o,
  output logic [hzb_pkg::DIST_W-1:0] dist_o [hzb_pkg::LANES]
);

  localparam int QW = hzb_pkg::QUOT_W;
  localparam int NS = hzb_pkg::DIST_W + 1;

  logic [NS-1:0]  valid_q;
  logic           fb_q  [NS];
  logic [QW-1:0]  x_q   [NS][hzb_pkg::LANES];
  logic [QW-1:0]  r_q   [NS][hzb_pkg::LANES];
  logic           bad_q [NS][hzb_pkg::LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [QW:0] b;
    logic [QW:0] rb;
    logic        ge;
    fb_q[0] <= fb_i;
    for (int l = 0; l < hzb_pkg::LANES; l++) begin
      x_q[0][l]   <= q_i[l];
      r_q[0][l]   <= '0;
      bad_q[0][l] <= bad_i[l];
    end
    for (int k = 1; k < NS; k++) begin
      fb_q[k] <= fb_q[k-1];
      b = (QW+1)'(1) << (2 * (NS - 1 - k));
      for (int l = 0; l < hzb_pkg::LANES; l++) begin
        rb = {1'b0, r_q[k-1][l]} + b;
        ge = {1'b0, x_q[k-1][l]} >= rb;
        x_q[k][l]   <= ge ? x_q[k-1][l] - rb[QW-1:0] : x_q[k-1][l];
        r_q[k][l]   <= ge ? (r_q[k-1][l] >> 1) + b[QW-1:0] : r_q[k-1][l] >> 1;
        bad_q[k][l] <= bad_q[k-1][l];
      end
    end
  end

  always_comb begin
    flags_o.fb  = fb_q[NS-1];
    flags_o.bad = 1'b0;
    for (int l = 0; l < hzb_pkg::LANES; l++) begin
      flags_o.bad = flags_o.bad | bad_q[NS-1][l];
      dist_o[l]   = bad_q[NS-1][l] ? hzb_pkg::DIST_SAT : r_q[NS-1][l][hzb_pkg::DIST_W-1:0];
    end
  end

  assign valid_o = valid_q[NS-1];

endmodule

FILE: sv/hzb_ratio.sv
// Width and normalised-bound ratios over the optimistic outer radius, plus result registers.
module hzb_ratio (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  hzb_pkg::hzb_flags_t         flags_i,
  input  logic [hzb_pkg::DIST_W-1:0]  dist_i  [hzb_pkg::LANES],
  output logic                        valid_o,
  output hzb_pkg::hzb_flags_t         flags_o,
  output logic [hzb_pkg::DIST_W-1:0]  dist_o  [hzb_pkg::LANES],
  output logic [hzb_pkg::RATIO_W-1:0] ratio_o [3]
);

  localparam int DW = hzb_pkg::DIST_W;
  localparam int RW = hzb_pkg::RATIO_W;
  localparam int NS = hzb_pkg::FRAC_BITS + 2;

  logic [NS:0]          valid_q;
  hzb_pkg::hzb_flags_t  flags_q [NS];
  logic [DW-1:0]        dist_q  [NS][hzb_pkg::LANES];
  logic [DW-1:0]        diff_q;
  logic                 zero_q  [NS];
  logic                 ovf_q   [NS][3];
  logic [DW-1:0]        rem_q   [NS][3];
  logic [RW-1:0]        qt_q    [NS][3];
  hzb_pkg::hzb_flags_t  flags_out_q;
  logic [DW-1:0]        dist_out_q [hzb_pkg::LANES];
  logic [RW-1:0]        ratio_q [3];
  logic [DW-1:0]        num_c   [3];

  always_comb begin
    num_c[0] = diff_q;
    num_c[1] = dist_q[0][1];
    num_c[2] = dist_q[0][2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DW:0] r2;
    logic        ge;
    flags_q[0] <= flags_i;
    dist_q[0]  <= dist_i;
    diff_q     <= (dist_i[3] > dist_i[0]) ? dist_i[3] - dist_i[0] : '0;

    flags_q[1] <= flags_q[0];
    dist_q[1]  <= dist_q[0];
    zero_q[1]  <= dist_q[0][3] == '0;
    for (int j = 0; j < 3; j++) begin
      ge = num_c[j] >= dist_q[0][3];
      ovf_q[1][j] <= {1'b0, num_c[j]} >= {dist_q[0][3], 1'b0};
      rem_q[1][j] <= ge ? num_c[j] - dist_q[0][3] : num_c[j];
      qt_q[1][j]  <= RW'(ge);
    end

    for (int k = 2; k < NS; k++) begin
      flags_q[k] <= flags_q[k-1];
      dist_q[k]  <= dist_q[k-1];
      zero_q[k]  <= zero_q[k-1];
      for (int j = 0; j < 3; j++) begin
        r2 = {rem_q[k-1][j], 1'b0};
        ge = r2 >= {1'b0, dist_q[k-1][3]};
        ovf_q[k][j] <= ovf_q[k-1][j];
        rem_q[k][j] <= ge ? DW'(r2 - {1'b0, dist_q[k-1][3]}) : r2[DW-1:0];
        qt_q[k][j]  <= {qt_q[k-1][j][RW-2:0], ge};
      end
    end

    flags_out_q <= flags_q[NS-1];
    dist_out_q  <= dist_q[NS-1];
    for (int j = 0; j < 3; j++) begin
      if (zero_q[NS-1]) begin
        ratio_q[j] <= '0;
      end else if (ovf_q[NS-1][j] || (qt_q[NS-1][j] > hzb_pkg::RATIO_CAP)) begin
        ratio_q[j] <= hzb_pkg::RATIO_CAP;
      end else begin
        ratio_q[j] <= qt_q[NS-1][j];
      end
    end
  end

  assign valid_o = valid_q[NS];
  assign flags_o = flags_out_q;
  assign dist_o  = dist_out_q;
  assign ratio_o = ratio_q;

endmodule

FILE: sv/habitable_zone_boundaries_top.sv
// Habitable-zone boundary pipeline: one star per clock in, one result per star out. The
// pipeline is made of two input stages, four Horner steps of 5 stages each, the 63-stage
// quotient divider, the 32-stage square root and the 19-stage ratio divider. busy is never
// raised and results cannot be held off, so each result is shown for exactly one cycle.
// Write the temperature limits over the APB port at byte addresses 0 (low) and 4 (high)
// only while no star is in flight; the block itself does not enforce this.
module habitable_zone_boundaries_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [hzb_pkg::TEMP_W-1:0]  star_temperature_i,
  input  logic [hzb_pkg::LUM_W-1:0]   star_luminosity_i,
  output logic                        result_valid_o,
  output logic [hzb_pkg::DIST_W-1:0]  optimistic_inner_o,
  output logic [hzb_pkg::DIST_W-1:0]  conservative_inner_o,
  output logic [hzb_pkg::DIST_W-1:0]  conservative_outer_o,
  output logic [hzb_pkg::DIST_W-1:0]  optimistic_outer_o,
  output logic [hzb_pkg::RATIO_W-1:0] width_ratio_o,
  output logic [hzb_pkg::RATIO_W-1:0] bound_inner_norm_o,
  output logic [hzb_pkg::RATIO_W-1:0] bound_outer_norm_o,
  output logic                        used_fallback_o,
  output logic                        flux_invalid_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hzb_pkg::ADDR_W-1:0]  paddr,
  input  logic [hzb_pkg::DATA_W-1:0]  pwdata,
  output logic [hzb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [hzb_pkg::TEMP_W-1:0] low_q, high_q;
  hzb_pkg::reg_idx_e          reg_idx;

  logic                          v0_q, v1_q;
  logic signed [hzb_pkg::T_W-1:0] t0_q;
  logic                          fb0_q;
  logic [hzb_pkg::PL_W-1:0]      pl0_q;
  logic [hzb_pkg::PH_W-1:0]      ph0_q;
  hzb_pkg::hzb_carry_t           c1_q;

  logic                hv   [5];
  hzb_pkg::hzb_carry_t hc   [5];
  hzb_pkg::acc_t       ha   [5][hzb_pkg::LANES];
  hzb_pkg::acc_t       coef [4][hzb_pkg::LANES];
  hzb_pkg::acc_t       seff [hzb_pkg::LANES];

  logic                       dv_v, dv_fb;
  logic [hzb_pkg::QUOT_W-1:0] dv_q_w [hzb_pkg::LANES];
  logic                       dv_bad [hzb_pkg::LANES];

  logic                       sq_v;
  hzb_pkg::hzb_flags_t        sq_flags;
  logic [hzb_pkg::DIST_W-1:0] sq_dist [hzb_pkg::LANES];

  hzb_pkg::hzb_flags_t         out_flags;
  logic [hzb_pkg::DIST_W-1:0]  out_dist  [hzb_pkg::LANES];
  logic [hzb_pkg::RATIO_W-1:0] out_ratio [3];

  assign reg_idx = hzb_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_comb begin
    unique case (reg_idx)
      hzb_pkg::REG_TEFF_LOW:  prdata = hzb_pkg::DATA_W'(low_q);
      hzb_pkg::REG_TEFF_HIGH: prdata = hzb_pkg::DATA_W'(high_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= hzb_pkg::LOW_RESET;
      high_q <= hzb_pkg::HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        hzb_pkg::REG_TEFF_LOW:  low_q  <= pwdata[hzb_pkg::TEMP_W-1:0];
        hzb_pkg::REG_TEFF_HIGH: high_q <= pwdata[hzb_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q  <= $signed({1'b0, star_temperature_i}) - $signed({1'b0, hzb_pkg::TEMP_REF});
    fb0_q <= (star_temperature_i > high_q) || (star_temperature_i < low_q);
    pl0_q <= hzb_pkg::PL_W'(star_luminosity_i[hzb_pkg::LL_W-1:0]) *
             hzb_pkg::PL_W'(hzb_pkg::SEFF_SCALE);
    ph0_q <= hzb_pkg::PH_W'(star_luminosity_i[hzb_pkg::LUM_W-1:hzb_pkg::LL_W]) *
             hzb_pkg::PH_W'(hzb_pkg::SEFF_SCALE);
    c1_q.t   <= t0_q;
    c1_q.fb  <= fb0_q;
    c1_q.num <= (hzb_pkg::NUM_W'(ph0_q) << hzb_pkg::LL_W) + hzb_pkg::NUM_W'(pl0_q);
  end

  assign hv[0] = v1_q;
  assign hc[0] = c1_q;

  for (genvar l = 0; l < hzb_pkg::LANES; l++) begin : g_lane
    assign ha[0][l] = hzb_pkg::FLUX_COEF[l][4];
  end

  always_comb begin
    for (int l = 0; l < hzb_pkg::LANES; l++) begin
      for (int h = 0; h < 4; h++) begin
        coef[h][l] = hzb_pkg::FLUX_COEF[l][3-h];
      end
    end
  end

  for (genvar h = 0; h < 4; h++) begin : g_horner
    hzb_horner u_horner (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (hv[h]),
      .carry_i (hc[h]),
      .acc_i   (ha[h]),
      .coef_i  (coef[h]),
      .valid_o (hv[h+1]),
      .carry_o (hc[h+1]),
      .acc_o   (ha[h+1])
    );
  end

  always_comb begin
    for (int l = 0; l < hzb_pkg::LANES; l++) begin
      if (hc[4].fb) begin
        seff[l] = (l < 2) ? hzb_pkg::SEFF_INNER : hzb_pkg::SEFF_OUTER;
      end else begin
        seff[l] = ha[4][l];
      end
    end
  end

  hzb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hv[4]),
    .fb_i    (hc[4].fb),
    .num_i   (hc[4].num),
    .seff_i  (seff),
    .valid_o (dv_v),
    .fb_o    (dv_fb),
    .q_o     (dv_q_w),
    .bad_o   (dv_bad)
  );

  hzb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_v),
    .fb_i    (dv_fb),
    .q_i     (dv_q_w),
    .bad_i   (dv_bad),
    .valid_o (sq_v),
    .flags_o (sq_flags),
    .dist_o  (sq_dist)
  );

  hzb_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .flags_i (sq_flags),
    .dist_i  (sq_dist),
    .valid_o (result_valid_o),
    .flags_o (out_flags),
    .dist_o  (out_dist),
    .ratio_o (out_ratio)
  );

  assign optimistic_inner_o   = out_dist[0];
  assign conservative_inner_o = out_dist[1];
  assign conservative_outer_o = out_dist[2];
  assign optimistic_outer_o   = out_dist[3];
  assign width_ratio_o        = out_ratio[0];
  assign bound_inner_norm_o   = out_ratio[1];
  assign bound_outer_norm_o   = out_ratio[2];
  assign used_fallback_o      = out_flags.fb;
  assign flux_invalid_o       = out_flags.bad;

endmodule

FILE: sv/hzb_checker.sv
// Port-level checks of the habitable-zone boundary block, bound to the top level.
module hzb_port_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic [hzb_pkg::DIST_W-1:0]  optimistic_inner_o,
  input logic [hzb_pkg::DIST_W-1:0]  conservative_inner_o,
  input logic [hzb_pkg::DIST_W-1:0]  conservative_outer_o,
  input logic [hzb_pkg::DIST_W-1:0]  optimistic_outer_o,
  input logic [hzb_pkg::RATIO_W-1:0] width_ratio_o,
  input logic [hzb_pkg::RATIO_W-1:0] bound_inner_norm_o,
  input logic [hzb_pkg::RATIO_W-1:0] bound_outer_norm_o,
  input logic                        used_fallback_o,
  input logic                        flux_invalid_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  a_ratio_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (width_ratio_o <= hzb_pkg::RATIO_CAP) &&
                       (bound_inner_norm_o <= hzb_pkg::RATIO_CAP) &&
                       (bound_outer_norm_o <= hzb_pkg::RATIO_CAP))
    else $error("ratio above cap");

  a_fallback_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && used_fallback_o) |->
      (optimistic_inner_o == conservative_inner_o) &&
      (conservative_outer_o == optimistic_outer_o))
    else $error("fallback bounds not paired");

  a_zero_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (optimistic_outer_o == '0)) |->
      (width_ratio_o == '0) && (bound_inner_norm_o == '0) && (bound_outer_norm_o == '0))
    else $error("ratio non-zero with zero outer radius");

  a_fallback_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && used_fallback_o && !flux_invalid_o) |->
      (optimistic_outer_o >= optimistic_inner_o))
    else $error("fallback outer below inner");

endmodule

bind habitable_zone_boundaries_top hzb_port_checker u_hzb_checker (.*);
